// File: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared types and constants: configuration register indexes and reset
// values, result kind codes, parser phases and the result record.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int MASK_W      = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INSTR_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_MASK    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]        RST_SYNC_FIRST  = 8'd5;
    localparam logic [7:0]        RST_SYNC_SECOND = 8'd9;
    localparam logic [7:0]        RST_INSTR_LIMIT = 8'd10;
    localparam logic [7:0]        RST_TIMEOUT     = 8'd15;
    localparam logic [MASK_W-1:0] RST_SUB_MASK    = '0;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD_SUM = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_LENGTH      = 2'd2,
        PH_BODY        = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]        sync_first;
        logic [7:0]        sync_second;
        logic [7:0]        instr_limit;
        logic [7:0]        timeout;
        logic [MASK_W-1:0] sub_mask;
    } t_cfg;

    typedef struct packed {
        logic [1:0] res_kind;
        logic [7:0] data_byte;
        logic [7:0] lead_byte;
        logic       is_instruction;
        logic [7:0] msg_type;
        logic       subscribed;
        logic       last;
    } t_result;

endpackage

// File: sv/sfd_parser.sv
// ----------------------------------------------------------------------------
// Serial frame deframer parser
// Frame state machine: sync hunt, length, body, checksum and tick timeout.
// Each accepted transfer updates the state and yields at most one result.
// ----------------------------------------------------------------------------
module sfd_parser import sfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_is_tick,
    input  logic [7:0] i_rx_byte,
    input  t_cfg    i_cfg,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_pos,   n_pos;
    logic [7:0] r_sum,   n_sum;
    logic [7:0] r_lead,  n_lead;
    logic [7:0] r_type,  n_type;
    logic [7:0] r_tick,  n_tick;

    logic [7:0] lead_now;
    logic       lead_ins;
    logic [7:0] tick_inc;
    logic       body_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT_FIRST;
            r_len   <= '0;
            r_pos   <= '0;
            r_sum   <= '0;
            r_lead  <= '0;
            r_type  <= '0;
            r_tick  <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_lead  <= n_lead;
            r_type  <= n_type;
            r_tick  <= n_tick;
        end
    end

    always_comb begin
        // The lead byte is taken from the first body byte as it arrives.
        lead_now  = (r_pos == 8'd0) ? i_rx_byte : r_lead;
        lead_ins  = lead_now < i_cfg.instr_limit;
        tick_inc  = (r_tick == 8'hFF) ? r_tick : r_tick + 8'd1;
        body_last = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};

        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_lead  = r_lead;
        n_type  = r_type;
        n_tick  = r_tick;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            if (i_is_tick) begin
                if (r_phase == PH_LENGTH || r_phase == PH_BODY) begin
                    n_tick = tick_inc;
                    if (tick_inc > i_cfg.timeout) begin
                        n_phase        = PH_HUNT_FIRST;
                        o_res_valid    = 1'b1;
                        o_res.res_kind = KIND_ABORT;
                        o_res.last     = 1'b1;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HUNT_FIRST: begin
                        if (i_rx_byte == i_cfg.sync_first) begin
                            n_phase = PH_HUNT_SECOND;
                        end
                    end
                    PH_HUNT_SECOND: begin
                        if (i_rx_byte == i_cfg.sync_second) begin
                            n_phase = PH_LENGTH;
                            n_tick  = '0;
                        end else if (i_rx_byte != i_cfg.sync_first) begin
                            n_phase = PH_HUNT_FIRST;
                        end
                    end
                    PH_LENGTH: begin
                        if (i_rx_byte == 8'd0) begin
                            n_phase        = PH_HUNT_FIRST;
                            o_res_valid    = 1'b1;
                            o_res.res_kind = KIND_ABORT;
                            o_res.last     = 1'b1;
                        end else begin
                            n_phase = PH_BODY;
                            n_len   = i_rx_byte;
                            n_sum   = i_rx_byte;
                            n_pos   = '0;
                            n_lead  = '0;
                            n_type  = '0;
                        end
                    end
                    PH_BODY: begin
                        n_lead               = lead_now;
                        o_res.lead_byte      = lead_now;
                        o_res.is_instruction = lead_ins;
                        o_res.msg_type       = lead_ins ? 8'd0 : r_type;
                        o_res.subscribed     = !lead_ins && (lead_now < 8'd64)
                                               && i_cfg.sub_mask[lead_now[5:0]];
                        if (body_last) begin
                            // The final body byte is the checksum.
                            n_phase        = PH_HUNT_FIRST;
                            o_res_valid    = 1'b1;
                            o_res.res_kind = (r_sum == i_rx_byte) ? KIND_GOOD
                                                                  : KIND_BAD_SUM;
                            o_res.last     = 1'b1;
                        end else begin
                            n_sum = r_sum + i_rx_byte;
                            n_pos = r_pos + 8'd1;
                            if (r_pos == 8'd1) begin
                                n_type = i_rx_byte;
                            end
                            if (r_pos >= 8'd2 && !lead_ins) begin
                                o_res_valid     = 1'b1;
                                o_res.res_kind  = KIND_PAYLOAD;
                                o_res.data_byte = i_rx_byte;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT_FIRST;
                    end
                endcase
            end
        end
    end

endmodule

// File: sv/sfd_outbuf.sv
// ----------------------------------------------------------------------------
// Serial frame deframer output buffer
// Output register plus one skid entry, so the parser keeps taking input
// while a result waits on the output side.
// ----------------------------------------------------------------------------
module sfd_outbuf import sfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    // The skid entry is only ever used behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register empty");

    // A held skid entry keeps its contents until the output drains.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry changed while waiting");

    // End results carry last; payload results never do.
    a_last_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.last == (r_out.res_kind != KIND_PAYLOAD)))
        else $error("last flag does not match result kind");

endmodule

// File: sv/serial_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// Serial frame deframer core
// Finds sync-delimited frames in a received byte stream, streams topic
// payload bytes and reports one end result per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Content
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: rx_byte, tuser: is_tick
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: result fields, tuser:
//                                                      res_kind, tlast: last
//  cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  Each input transfer is parsed combinationally; a new one is taken every cycle
//  while s_axis_tready is high. Results wait in the output register or skid entry.
//  Reset is synchronous and active low; it restores the register defaults and
//  puts the parser back to hunting the first sync byte.
//  The output register has one skid entry behind it; s_axis_tready drops
//  only while that entry is occupied, i.e. after two results are stalled.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module serial_frame_deframer_core import sfd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tuser,   // [0] is_tick

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_byte, [15:8] lead_byte, [16] is_instruction,
    // [24:17] msg_type, [25] subscribed, [31:26] zero
    output logic [31:0]            m_axis_tdata,
    output logic [1:0]             m_axis_tuser,   // [1:0] res_kind
    output logic                   m_axis_tlast,   // last

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]      i_cfg_data
);

    t_cfg    r_cfg;
    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    space;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = space;
    assign in_accept     = s_axis_tvalid && space;

    // Configuration registers. Writes to indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= RST_SYNC_FIRST;
            r_cfg.sync_second <= RST_SYNC_SECOND;
            r_cfg.instr_limit <= RST_INSTR_LIMIT;
            r_cfg.timeout     <= RST_TIMEOUT;
            r_cfg.sub_mask    <= RST_SUB_MASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                REG_INSTR_LIMIT: r_cfg.instr_limit <= i_cfg_data[7:0];
                REG_TIMEOUT:     r_cfg.timeout     <= i_cfg_data[7:0];
                REG_SUB_MASK:    r_cfg.sub_mask    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Frame state machine: one step per accepted transfer.
    sfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_is_tick   (s_axis_tuser),
        .i_rx_byte   (s_axis_tdata),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register with skid entry, decoupling the two stream sides.
    sfd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {6'd0, out_res.subscribed, out_res.msg_type,
                           out_res.is_instruction, out_res.lead_byte,
                           out_res.data_byte};
    assign m_axis_tuser = out_res.res_kind;
    assign m_axis_tlast = out_res.last;

endmodule

// File: bench/sfd_checker.sv
// ----------------------------------------------------------------------------
// Serial frame deframer checker
// Watches the input, result and register channels of the deframer, keeps its
// own model of the parser and the registers, and compares each result
// transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [7:0]             i_s_tdata,    // [7:0] rx_byte
    input  logic                   i_s_tuser,    // [0] is_tick

    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [7:0] data_byte, [15:8] lead_byte, [16] is_instruction,
    // [24:17] msg_type, [25] subscribed, [31:26] zero
    input  logic [31:0]            i_m_tdata,
    input  logic [1:0]             i_m_tuser,    // [1:0] res_kind
    input  logic                   i_m_tlast,    // last

    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]      i_cfg_data,

    input  logic                   i_done,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int PRINT_CAP = 40;

    t_cfg       regs;
    t_phase     phase;
    logic [7:0] frame_len;
    logic [7:0] body_pos;
    logic [7:0] byte_sum;
    logic [7:0] lead_held;
    logic [7:0] type_held;
    logic [7:0] tick_cnt;

    t_result    frames_due[$];
    int         fails;
    int         checked;
    bit         leftover_seen;

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        fails++;
        if (fails <= PRINT_CAP)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Builds the result record from the frame fields held so far.
    function automatic t_result frame_record(input logic [1:0] kind, input logic [7:0] data,
                                             input logic info, input logic is_end);
        t_result r;
        logic    ins;
        ins              = lead_held < regs.instr_limit;
        r.res_kind       = kind;
        r.data_byte      = data;
        r.lead_byte      = info ? lead_held : 8'd0;
        r.is_instruction = info && ins;
        r.msg_type       = (info && !ins) ? type_held : 8'd0;
        r.subscribed     = (info && !ins && lead_held < 8'd64) ?
                           regs.sub_mask[lead_held[5:0]] : 1'b0;
        r.last           = is_end;
        return r;
    endfunction

    task automatic abort_frame();
        phase = PH_HUNT_FIRST;
        frames_due.push_back(frame_record(KIND_ABORT, 8'd0, 1'b0, 1'b1));
    endtask

    // Advances the parser model by one accepted input transfer.
    task automatic parse_item(input logic tick, input logic [7:0] b);
        logic is_end;
        if (tick) begin
            // Ticks only count while a frame is open.
            if (phase == PH_LENGTH || phase == PH_BODY) begin
                if (tick_cnt != 8'hFF)
                    tick_cnt++;
                if (tick_cnt > regs.timeout)
                    abort_frame();
            end
            return;
        end
        case (phase)
            PH_HUNT_FIRST: begin
                if (b == regs.sync_first)
                    phase = PH_HUNT_SECOND;
            end
            PH_HUNT_SECOND: begin
                if (b == regs.sync_second) begin
                    phase    = PH_LENGTH;
                    tick_cnt = 8'd0;
                end else if (b != regs.sync_first) begin
                    phase = PH_HUNT_FIRST;
                end
            end
            PH_LENGTH: begin
                if (b == 8'd0) begin
                    abort_frame();
                end else begin
                    frame_len = b;
                    byte_sum  = b;
                    body_pos  = 8'd0;
                    lead_held = 8'd0;
                    type_held = 8'd0;
                    phase     = PH_BODY;
                end
            end
            default: begin
                is_end = ({1'b0, body_pos} + 9'd1) >= {1'b0, frame_len};
                if (body_pos == 8'd0)
                    lead_held = b;
                if (is_end) begin
                    // The closing byte is the checksum and is never passed on.
                    phase = PH_HUNT_FIRST;
                    frames_due.push_back(frame_record((byte_sum == b) ? KIND_GOOD : KIND_BAD_SUM,
                                                      8'd0, 1'b1, 1'b1));
                end else begin
                    byte_sum = byte_sum + b;
                    if (body_pos == 8'd1)
                        type_held = b;
                    if (body_pos >= 8'd2 && !(lead_held < regs.instr_limit))
                        frames_due.push_back(frame_record(KIND_PAYLOAD, b, 1'b1, 1'b0));
                    body_pos++;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            regs.sync_first  = RST_SYNC_FIRST;
            regs.sync_second = RST_SYNC_SECOND;
            regs.instr_limit = RST_INSTR_LIMIT;
            regs.timeout     = RST_TIMEOUT;
            regs.sub_mask    = RST_SUB_MASK;
            phase            = PH_HUNT_FIRST;
            frame_len        = 8'd0;
            body_pos         = 8'd0;
            byte_sum         = 8'd0;
            lead_held        = 8'd0;
            type_held        = 8'd0;
            tick_cnt         = 8'd0;
            frames_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SYNC_FIRST:  regs.sync_first  = i_cfg_data[7:0];
                    REG_SYNC_SECOND: regs.sync_second = i_cfg_data[7:0];
                    REG_INSTR_LIMIT: regs.instr_limit = i_cfg_data[7:0];
                    REG_TIMEOUT:     regs.timeout     = i_cfg_data[7:0];
                    REG_SUB_MASK:    regs.sub_mask    = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                if (frames_due.size() == 0) begin
                    report("unexpected result, res_kind", 64'(i_m_tuser), 64'(0));
                end else begin
                    want = frames_due.pop_front();
                    checked++;
                    if (i_m_tuser != want.res_kind)
                        report("res_kind", 64'(i_m_tuser), 64'(want.res_kind));
                    if (i_m_tdata[7:0] != want.data_byte)
                        report("data_byte", 64'(i_m_tdata[7:0]), 64'(want.data_byte));
                    if (i_m_tdata[15:8] != want.lead_byte)
                        report("lead_byte", 64'(i_m_tdata[15:8]), 64'(want.lead_byte));
                    if (i_m_tdata[16] != want.is_instruction)
                        report("is_instruction", 64'(i_m_tdata[16]),
                               64'(want.is_instruction));
                    if (i_m_tdata[24:17] != want.msg_type)
                        report("msg_type", 64'(i_m_tdata[24:17]), 64'(want.msg_type));
                    if (i_m_tdata[25] != want.subscribed)
                        report("subscribed", 64'(i_m_tdata[25]), 64'(want.subscribed));
                    if (i_m_tdata[31:26] != 6'd0)
                        report("tdata padding", 64'(i_m_tdata[31:26]), 64'(0));
                    if (i_m_tlast != want.last)
                        report("last", 64'(i_m_tlast), 64'(want.last));
                end
            end

            if (i_s_tvalid && i_s_tready)
                parse_item(i_s_tuser, i_s_tdata);

            if (i_done && !leftover_seen) begin
                leftover_seen = 1'b1;
                if (frames_due.size() != 0)
                    report("results never delivered, count", 64'(0),
                           64'(frames_due.size()));
            end
        end
        o_pending    <= frames_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Serial frame deframer testbench
// Drives received bytes and time ticks into the deframer under random source
// gaps and sink stalls, and steps the registers through several settings;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import sfd_pkg::*;

    // No transfer on any channel for this many cycles means the block hangs.
    localparam int WATCHDOG_LIMIT = 2000;
    // Byte transfers in each random phase of traffic.
    localparam int PHASE_BYTES    = 30;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'd0;   // [7:0] rx_byte
    logic                   s_axis_tuser  = 1'b0;   // [0] is_tick

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] data_byte, [15:8] lead_byte, [16] is_instruction,
    // [24:17] msg_type, [25] subscribed, [31:26] zero
    logic [31:0]            m_axis_tdata;
    logic [1:0]             m_axis_tuser;           // [1:0] res_kind
    logic                   m_axis_tlast;           // last

    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = REG_SYNC_FIRST;
    logic [MASK_W-1:0]      i_cfg_data    = '0;

    logic                   check_done    = 1'b0;
    int                     fail_count;
    int                     pending;
    int                     checked;

    // Settings currently in the block, so that frames can be built to match.
    t_cfg                   cur_cfg;
    int                     n_bytes;
    int                     n_ticks;
    int                     n_settings;
    bit                     idle_on;
    int                     stall_left;
    int                     idle_cycles;

    always #4 i_clk = ~i_clk;

    serial_frame_deframer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sfd_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_done       (check_done),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Lead bytes cover instructions, subscribable topic ids and high ids.
    function automatic logic [7:0] pick_lead();
        int lim;
        lim = int'(cur_cfg.instr_limit);
        if (lim > 0 && $urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, lim - 1));
        if (lim <= 63 && $urandom_range(0, 1) == 0)
            return 8'($urandom_range(lim, 63));
        return 8'($urandom_range(lim, 255));
    endfunction

    // Sink side: tready drops for random stretches while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= gap_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One input transfer. Valid is only lowered when a gap is taken, so a
    // back-to-back transfer keeps it high without a second assignment.
    task automatic send(input logic tick, input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= tick;
        do @(posedge i_clk); while (!s_axis_tready);
        if (tick)
            n_ticks++;
        else
            n_bytes++;
    endtask

    // Holds the source until every predicted result has been delivered, then
    // lets the pipeline settle for frames that end without a result.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [MASK_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes every register; only called while the block is idle.
    task automatic set_registers(input t_cfg c);
        write_reg(REG_SYNC_FIRST,  {56'd0, c.sync_first});
        write_reg(REG_SYNC_SECOND, {56'd0, c.sync_second});
        write_reg(REG_INSTR_LIMIT, {56'd0, c.instr_limit});
        write_reg(REG_TIMEOUT,     {56'd0, c.timeout});
        write_reg(REG_SUB_MASK,    c.sub_mask);
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
        n_settings++;
    endtask

    // A well-formed frame under the current settings. Stray ticks stay within
    // the timeout unless a timeout abort is asked for; the checksum byte can
    // be corrupted by flipping one bit.
    task automatic send_frame(input logic [7:0] lead, input int nbody,
                              input bit bad_sum, input bit time_out);
        logic [7:0] sum_acc;
        logic [7:0] b;
        int         ticks_left;
        int         abort_at;
        send(1'b0, cur_cfg.sync_first);
        send(1'b0, cur_cfg.sync_second);
        send(1'b0, 8'(nbody));
        sum_acc    = 8'(nbody);
        ticks_left = int'(cur_cfg.timeout);
        abort_at   = time_out ? $urandom_range(0, nbody - 1) : -1;
        for (int i = 0; i < nbody; i++) begin
            if (i == abort_at) begin
                repeat (int'(cur_cfg.timeout) + 1) send(1'b1, 8'($urandom));
                return;
            end
            if (ticks_left > 0 && $urandom_range(0, 9) == 0) begin
                send(1'b1, 8'($urandom));
                ticks_left--;
            end
            if (i == nbody - 1)
                b = bad_sum ? (sum_acc ^ (8'd1 << $urandom_range(0, 7))) : sum_acc;
            else if (i == 0)
                b = lead;
            else
                b = 8'($urandom);
            sum_acc = sum_acc + b;
            send(1'b0, b);
        end
    endtask

    // Random traffic: mostly good frames with random content, the rest noise
    // around the sync bytes, cut-off frames and a pause until drained.
    task automatic run_traffic(input int quota);
        int stop_at;
        int r;
        int len;
        stop_at = n_bytes + quota;
        while (n_bytes < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 68) begin
                len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_frame(pick_lead(), len, $urandom_range(0, 4) == 0,
                           cur_cfg.timeout < 32 && $urandom_range(0, 9) == 0);
            end else if (r < 83) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 9);
                    if (r < 3)
                        send(1'b1, 8'($urandom));
                    else if (r < 6)
                        send(1'b0, cur_cfg.sync_first);
                    else if (r < 8)
                        send(1'b0, cur_cfg.sync_second);
                    else
                        send(1'b0, 8'($urandom));
                end
            end else if (r < 96) begin
                // Header and a partial body, or a zero length that aborts: after a body, what follows lands inside it.
                send(1'b0, cur_cfg.sync_first);
                send(1'b0, cur_cfg.sync_second);
                len = $urandom_range(0, 20);
                send(1'b0, 8'(len));
                if (len > 0)
                    repeat ($urandom_range(0, len - 1)) send(1'b0, 8'($urandom));
            end else begin
                wait_idle();
            end
        end
    endtask

    initial begin
        t_cfg c;
        cur_cfg.sync_first  = RST_SYNC_FIRST;
        cur_cfg.sync_second = RST_SYNC_SECOND;
        cur_cfg.instr_limit = RST_INSTR_LIMIT;
        cur_cfg.timeout     = RST_TIMEOUT;
        cur_cfg.sub_mask    = RST_SUB_MASK;
        idle_on = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset settings. A tick while hunting is
        // ignored, a repeated first sync byte keeps the hunt, and a zero length
        // aborts the frame.
        send(1'b1, 8'hFF);
        send(1'b0, 8'h05);
        send(1'b0, 8'h05);
        send(1'b0, 8'h09);
        send(1'b0, 8'h00);
        // One-byte body, where the lead byte doubles as the checksum.
        send_frame(8'd0, 1, 1'b0, 1'b0);
        // Two-byte topic body with a topic id above 63: no message type.
        send_frame(8'd200, 2, 1'b0, 1'b0);
        // Instruction frame with a bad checksum: no payload goes out.
        send_frame(8'd3, 4, 1'b1, 1'b0);
        // Topic frame with payload at the last subscribable id.
        send_frame(8'd63, 4, 1'b0, 1'b0);
        wait_idle();

        // Low extremes: every lead byte is a topic, every tick in a frame
        // aborts it, every topic below 64 is subscribed.
        c.sync_first  = 8'h00;
        c.sync_second = 8'hFF;
        c.instr_limit = 8'd0;
        c.timeout     = 8'd0;
        c.sub_mask    = '1;
        set_registers(c);
        run_traffic(PHASE_BYTES);
        wait_idle();

        // High extremes: the timeout never fires, even past a saturated
        // tick count, and nearly every lead byte is an instruction.
        c.sync_first  = 8'hFF;
        c.sync_second = 8'h00;
        c.instr_limit = 8'hFF;
        c.timeout     = 8'hFF;
        c.sub_mask    = '0;
        set_registers(c);
        send(1'b0, c.sync_first);
        send(1'b0, c.sync_second);
        send(1'b0, 8'd3);
        repeat (260) send(1'b1, 8'($urandom));
        send_frame(8'hFF, 5, 1'b0, 1'b0);
        run_traffic(PHASE_BYTES);
        wait_idle();

        // Both sync bytes equal, and a stretch without any idling.
        idle_on       = 1'b0;
        c.sync_first  = 8'($urandom);
        c.sync_second = c.sync_first;
        c.instr_limit = 8'd64;
        c.timeout     = 8'($urandom_range(2, 20));
        c.sub_mask    = {$urandom, $urandom};
        set_registers(c);
        run_traffic(PHASE_BYTES);
        wait_idle();

        // Fully random settings.
        repeat (2) begin
            idle_on       = 1'b1;
            c.sync_first  = 8'($urandom);
            c.sync_second = 8'($urandom);
            c.instr_limit = 8'($urandom);
            c.timeout     = 8'($urandom_range(0, 40));
            c.sub_mask    = {$urandom, $urandom};
            set_registers(c);
            run_traffic(PHASE_BYTES);
            wait_idle();
        end

        check_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("Run covered %0d bytes and %0d ticks over %0d register settings.",
                 n_bytes, n_ticks, n_settings + 1);
        $display("%0d results were compared against the frame model.", checked);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
